// ===== sv/assert_macros.svh =====
// Assertion helpers included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/bhcs_pkg.sv =====
package bhcs_pkg;

    // Field and register widths
    localparam int CLK_W        = 28;
    localparam int ADDR_W       = 28;
    localparam int CNT_W        = 5;
    localparam int PHASE_W      = 5;
    localparam int HOP_W        = 7;
    localparam int SUM_W        = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 28;
    localparam int NUM_FLY      = 14;

    // Channel count and the split point of the even/odd remap
    localparam int NUM_CHANNELS  = 79;
    localparam int HALF_CHANNELS = (NUM_CHANNELS + 1) / 2;

    // Sequence modes; the code 7 is unused
    typedef enum logic [2:0] {
        MODE_PAGE_SCAN   = 3'd0,
        MODE_INQ_SCAN    = 3'd1,
        MODE_PAGE        = 3'd2,
        MODE_INQUIRY     = 3'd3,
        MODE_CENTRAL_RSP = 3'd4,
        MODE_PERIPH_RSP  = 3'd5,
        MODE_INQ_RSP     = 3'd6
    } t_seq_mode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 3'd0,
        CFG_ADDRESS = 3'd1,
        CFG_OFFSET  = 3'd2,
        CFG_NUDGE   = 3'd3
    } t_cfg_index;

    // Configuration as seen by the datapath, address already split into keys
    typedef struct packed {
        t_seq_mode          mode;
        logic [4:0]         key_a;
        logic [3:0]         key_b;
        logic [4:0]         key_c;
        logic [8:0]         key_d;
        logic [6:0]         key_e;
        logic [PHASE_W-1:0] offset;
        logic [PHASE_W-1:0] nudge;
    } t_hop_cfg;

    // Stage payloads
    typedef struct packed {
        logic [PHASE_W-1:0] x;
        logic               y1;
    } t_s1;

    typedef struct packed {
        logic [PHASE_W-1:0] z;
        logic               y1;
    } t_s2;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
    } t_s3;

    // Butterfly bit pairs for controls P0..P13
    localparam logic [2:0] FLY_LO [NUM_FLY] = '{
        3'd0, 3'd2, 3'd1, 3'd3, 3'd0, 3'd1, 3'd0,
        3'd3, 3'd1, 3'd0, 3'd2, 3'd1, 3'd0, 3'd1
    };
    localparam logic [2:0] FLY_HI [NUM_FLY] = '{
        3'd1, 3'd3, 3'd2, 3'd4, 3'd4, 3'd3, 3'd2,
        3'd4, 3'd4, 3'd3, 3'd4, 3'd3, 3'd3, 3'd2
    };

    // Upper clock phase bits CLK[16:12]
    function automatic logic [PHASE_W-1:0] clk_hi5(input logic [CLK_W-1:0] clk);
        return clk[16:12];
    endfunction

    // Train phase: hi + train offset + k_nudge + ((CLK[4:2,0] - hi) mod 16), mod 32
    function automatic logic [PHASE_W-1:0] train_phase(
        input logic [CLK_W-1:0]   clk,
        input logic [PHASE_W-1:0] offset,
        input logic [PHASE_W-1:0] nudge
    );
        logic [PHASE_W-1:0] hi;
        logic [3:0]         lo;
        logic [3:0]         dif;
        hi  = clk[16:12];
        lo  = {clk[4:2], clk[0]};
        dif = lo - hi[3:0];
        return hi + offset + nudge + {1'b0, dif};
    endfunction

    // One butterfly: swap the pair when enabled
    function automatic logic [PHASE_W-1:0] fly_step(
        input logic [PHASE_W-1:0] z,
        input logic               en,
        input logic [3:0]         sel
    );
        logic [PHASE_W-1:0] r;
        logic [2:0]         lo;
        logic [2:0]         hi;
        r  = z;
        lo = FLY_LO[sel];
        hi = FLY_HI[sel];
        if (en && (z[lo] != z[hi])) begin
            r[lo] = z[hi];
            r[hi] = z[lo];
        end
        return r;
    endfunction

endpackage

// ===== sv/bt_hop_channel_select.sv =====
// Bluetooth BR/EDR hop selection for page, inquiry and response sequences.
// Input channel (i_in_valid / o_in_ready) carries one slot: native clock,
// frozen clock and response counter. Output channel (o_out_valid /
// i_out_ready) returns the RF channel and the kernel hop index.
// Config channel (i_cfg_valid / o_cfg_ready, always ready) writes mode,
// 28-bit address, train offset and k_nudge; write only while the block is empty.
// A result passes four register stages: phase, two butterfly stages with the
// E/Y2 add, mod-79 reduce and remap.
// Throughput: one item per cycle while i_out_ready is high; each of the four
// register stages can take a new item in the same cycle it passes its own one on.
// Reset: synchronous, active low; clears all stage valid bits and loads
// mode page scan, address 0, train offset 24, k_nudge 0.
// Stall: when i_out_ready is low the result holds, and the stall backs up
// stage by stage; bubbles in the pipe still fill, so up to four items sit
// inside before o_in_ready falls. Nothing is dropped or repeated.
module bt_hop_channel_select
    import bhcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CLK_W-1:0]      i_native_clock,
    input  logic [CLK_W-1:0]      i_frozen_clock,
    input  logic [CNT_W-1:0]      i_response_count,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [HOP_W-1:0]      o_rf_channel,
    output logic [HOP_W-1:0]      o_hop_index
);

    t_hop_cfg cfg;
    logic     s1_valid;
    logic     s1_ready;
    t_s1      s1;
    logic     s3_valid;
    logic     s3_ready;
    t_s3      s3;

    assign o_cfg_ready = 1'b1;

    // Config registers and address keys
    bhcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Stage 1: phase X and Y1
    bhcs_phase u_phase (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_native_clock   (i_native_clock),
        .i_frozen_clock   (i_frozen_clock),
        .i_response_count (i_response_count),
        .o_valid          (s1_valid),
        .i_ready          (s1_ready),
        .o_s1             (s1)
    );

    // Stages 2 and 3: add A, xor B, butterfly permutation, add E and Y2
    bhcs_scramble u_scramble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_s1    (s1),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_s3    (s3)
    );

    // Stage 4: mod 79 and channel remap
    bhcs_map u_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s3_valid),
        .o_ready      (s3_ready),
        .i_s3         (s3),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_rf_channel (o_rf_channel),
        .o_hop_index  (o_hop_index)
    );

endmodule

// ===== sv/bhcs_cfg.sv =====
module bhcs_cfg
    import bhcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_hop_cfg              o_cfg
);

    t_seq_mode          r_mode;
    logic [ADDR_W-1:0]  r_addr;
    logic [PHASE_W-1:0] r_offset;
    logic [PHASE_W-1:0] r_nudge;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PAGE_SCAN;
            r_addr   <= '0;
            r_offset <= PHASE_W'(24);
            r_nudge  <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MODE:    r_mode   <= t_seq_mode'(i_cfg_data[2:0]);
                CFG_ADDRESS: r_addr   <= i_cfg_data[ADDR_W-1:0];
                CFG_OFFSET:  r_offset <= i_cfg_data[PHASE_W-1:0];
                CFG_NUDGE:   r_nudge  <= i_cfg_data[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    // Address keys A..E
    always_comb begin
        o_cfg.mode   = r_mode;
        o_cfg.key_a  = r_addr[27:23];
        o_cfg.key_b  = r_addr[22:19];
        o_cfg.key_c  = {r_addr[8], r_addr[6], r_addr[4], r_addr[2], r_addr[0]};
        o_cfg.key_d  = r_addr[18:10];
        o_cfg.key_e  = {r_addr[13], r_addr[11], r_addr[9], r_addr[7],
                        r_addr[5], r_addr[3], r_addr[1]};
        o_cfg.offset = r_offset;
        o_cfg.nudge  = r_nudge;
    end

endmodule

// ===== sv/bhcs_phase.sv =====
module bhcs_phase
    import bhcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_hop_cfg           i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CLK_W-1:0]   i_native_clock,
    input  logic [CLK_W-1:0]   i_frozen_clock,
    input  logic [CNT_W-1:0]   i_response_count,
    output logic               o_valid,
    input  logic               i_ready,
    output t_s1                o_s1
);

    logic  r_valid;
    t_s1   r_s1;
    t_s1   n_s1;

    // Phase X and Y1 per sequence mode
    always_comb begin
        n_s1 = '0;
        case (i_cfg.mode)
            MODE_PAGE_SCAN: begin
                n_s1.x = clk_hi5(i_native_clock);
            end
            MODE_INQ_SCAN: begin
                n_s1.x = clk_hi5(i_native_clock) + i_response_count;
            end
            MODE_PAGE, MODE_INQUIRY: begin
                n_s1.x  = train_phase(i_native_clock, i_cfg.offset, i_cfg.nudge);
                n_s1.y1 = i_native_clock[1];
            end
            MODE_CENTRAL_RSP: begin
                n_s1.x  = train_phase(i_frozen_clock, i_cfg.offset, i_cfg.nudge)
                          + i_response_count;
                n_s1.y1 = i_native_clock[1];
            end
            MODE_PERIPH_RSP: begin
                n_s1.x  = clk_hi5(i_frozen_clock) + i_response_count;
                n_s1.y1 = i_native_clock[1];
            end
            MODE_INQ_RSP: begin
                n_s1.x  = clk_hi5(i_native_clock) + i_response_count;
                n_s1.y1 = 1'b1;
            end
            default: n_s1 = '0;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

// ===== sv/bhcs_scramble.sv =====
module bhcs_scramble
    import bhcs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_hop_cfg i_cfg,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_s1      i_s1,
    output logic     o_valid,
    input  logic     i_ready,
    output t_s3      o_s3
);

    logic               r_valid2;
    logic               r_valid3;
    t_s2                r_s2;
    t_s3                r_s3;
    t_s2                n_s2;
    t_s3                n_s3;
    logic               ready2;
    logic               ready3;
    logic [NUM_FLY-1:0] ctl;
    logic [PHASE_W-1:0] z_a;
    logic [PHASE_W-1:0] z_b;

    // Controls: P13..P9 from C xor Y1, P8..P0 from D
    assign ctl = {i_cfg.key_c ^ {PHASE_W{i_s1.y1}}, i_cfg.key_d};

    // Add A, xor B, first half of the butterflies (P13..P7)
    always_comb begin
        z_a = (i_s1.x + i_cfg.key_a) ^ {1'b0, i_cfg.key_b};
        for (int i = NUM_FLY - 1; i >= 7; i--) begin
            z_a = fly_step(z_a, ctl[i], 4'(i));
        end
        n_s2.z  = z_a;
        n_s2.y1 = i_s1.y1;
    end

    // Second half (P6..P0, all from D), then add E and Y2 = 32 * Y1
    always_comb begin
        z_b = r_s2.z;
        for (int i = 6; i >= 0; i--) begin
            z_b = fly_step(z_b, i_cfg.key_d[i], 4'(i));
        end
        n_s3.sum = SUM_W'(z_b) + SUM_W'(i_cfg.key_e) + {2'b00, r_s2.y1, 5'd0};
    end

    assign ready3  = !r_valid3 || i_ready;
    assign ready2  = !r_valid2 || ready3;
    assign o_ready = ready2;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            if (ready2) begin
                r_valid2 <= i_valid;
            end
            if (ready3) begin
                r_valid3 <= r_valid2;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (ready2 && i_valid) begin
            r_s2 <= n_s2;
        end
        if (ready3 && r_valid2) begin
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_valid3;
    assign o_s3    = r_s3;

endmodule

// ===== sv/bhcs_map.sv =====
module bhcs_map
    import bhcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_s3              i_s3,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [HOP_W-1:0] o_rf_channel,
    output logic [HOP_W-1:0] o_hop_index
);

    logic             r_valid;
    logic [HOP_W-1:0] r_rf;
    logic [HOP_W-1:0] r_idx;
    logic [HOP_W-1:0] n_rf;
    logic [HOP_W-1:0] n_idx;

    // Sum is below three times the channel count: at most two subtracts
    always_comb begin
        if (i_s3.sum >= SUM_W'(2 * NUM_CHANNELS)) begin
            n_idx = HOP_W'(i_s3.sum - SUM_W'(2 * NUM_CHANNELS));
        end else if (i_s3.sum >= SUM_W'(NUM_CHANNELS)) begin
            n_idx = HOP_W'(i_s3.sum - SUM_W'(NUM_CHANNELS));
        end else begin
            n_idx = HOP_W'(i_s3.sum);
        end
        // Evens first, then odds
        if (n_idx < HOP_W'(HALF_CHANNELS)) begin
            n_rf = {n_idx[HOP_W-2:0], 1'b0};
        end else begin
            n_rf = HOP_W'({n_idx - HOP_W'(HALF_CHANNELS), 1'b1});
        end
    end

    assign o_ready = !r_valid || i_out_ready;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rf  <= n_rf;
            r_idx <= n_idx;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_rf_channel = r_rf;
    assign o_hop_index  = r_idx;

endmodule

// ===== sv/bhcs_checker.sv =====
`include "assert_macros.svh"

module bhcs_checker
    import bhcs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [HOP_W-1:0]      o_rf_channel,
    input logic [HOP_W-1:0]      o_hop_index
);

    // Stalled result stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // Stalled result keeps its payload
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_rf_channel) && $stable(o_hop_index))

    // Both fields stay inside the channel range
    `ASSERT_IMPL(a_range, i_clk, i_rst_n, o_out_valid, (o_hop_index < HOP_W'(NUM_CHANNELS)) && (o_rf_channel < HOP_W'(NUM_CHANNELS)))

    // Remap: low half of the index lands on even channels, upper half on odd
    `ASSERT_IMPL(a_remap_parity, i_clk, i_rst_n, o_out_valid, o_rf_channel[0] == (o_hop_index >= HOP_W'(HALF_CHANNELS)))

endmodule

bind bt_hop_channel_select bhcs_checker u_bhcs_checker (.*);

// ===== verif/bt_hop_channel_select_test.sv =====
`timescale 1ns / 100ps

module bt_hop_channel_select_test;
    import bhcs_pkg::*;

    localparam int HALF_PERIOD       = 6;
    localparam int RESET_CYCLES      = 5;
    localparam int PIPE_LATENCY      = 4;
    localparam int SETTLE_CYCLES     = PIPE_LATENCY + 4;
    localparam int HOLD_CYCLES       = 40;
    localparam int HOLD_SLOTS        = 30;
    localparam int STALL_LIMIT       = 2000;
    localparam int NUM_SETTINGS      = 16;
    localparam int SLOTS_PER_SETTING = 62;
    localparam int HOLD_SETTING      = 2;
    localparam int MAX_PRINTED       = 100;
    localparam int NUM_MODES         = 8;
    localparam int SPARE_INDEX_LO    = 4;
    localparam int SPARE_INDEX_HI    = 7;

    // mode code left unassigned by the package
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    localparam logic [CLK_W-1:0]   CLK_MAX   = '1;
    localparam logic [ADDR_W-1:0]  ADDR_MAX  = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
    localparam logic [PHASE_W-1:0] PHASE_MAX = '1;

    // butterfly swap pairs, control P0 first
    localparam int SWAP_LO [NUM_FLY] = '{0, 2, 1, 3, 0, 1, 0, 3, 1, 0, 2, 1, 0, 1};
    localparam int SWAP_HI [NUM_FLY] = '{1, 3, 2, 4, 4, 3, 2, 4, 4, 3, 4, 3, 3, 2};

    typedef struct packed {
        logic [HOP_W-1:0] rf_channel;
        logic [HOP_W-1:0] hop_index;
    } hop_result_t;

    // Hop predictor with its own register copy, plus the queue of pending hops
    class hop_scoreboard;
        logic [2:0]         mode;
        logic [ADDR_W-1:0]  addr;
        logic [PHASE_W-1:0] trn_offset;
        logic [PHASE_W-1:0] k_nudge;
        hop_result_t        expected_hops[$];
        int                 errors;
        int                 results_checked;

        function void reset_regs();
            mode       = MODE_PAGE_SCAN;
            addr       = '0;
            trn_offset = 5'd24;
            k_nudge    = '0;
        endfunction

        // spare indexes fall through; data bits above a register's width drop
        function void write_reg(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_MODE:    mode       = data[2:0];
                CFG_ADDRESS: addr       = data[ADDR_W-1:0];
                CFG_OFFSET:  trn_offset = data[PHASE_W-1:0];
                CFG_NUDGE:   k_nudge    = data[PHASE_W-1:0];
                default:     ;
            endcase
        endfunction

        // page/inquiry train phase, wraps at 5 bits
        function logic [PHASE_W-1:0] train_sum(input logic [CLK_W-1:0] clk);
            logic [3:0] slip;
            slip = {clk[4:2], clk[0]} - clk[15:12];
            return clk[16:12] + trn_offset + k_nudge + {1'b0, slip};
        endfunction

        function hop_result_t predict(input logic [CLK_W-1:0] nat,
                                      input logic [CLK_W-1:0] frz,
                                      input logic [CNT_W-1:0] cnt);
            logic [PHASE_W-1:0] x;
            logic               y1;
            logic [4:0]         key_a;
            logic [3:0]         key_b;
            logic [4:0]         key_c;
            logic [8:0]         key_d;
            logic [6:0]         key_e;
            logic [4:0]         z;
            logic [4:0]         cy;
            logic [13:0]        ctl;
            logic               t;
            logic [7:0]         sum;
            logic [HOP_W-1:0]   idx;
            hop_result_t        res;

            // phase and Y1 per sequence mode
            case (mode)
                MODE_PAGE_SCAN: begin
                    x  = nat[16:12];
                    y1 = 1'b0;
                end
                MODE_INQ_SCAN: begin
                    x  = nat[16:12] + cnt;
                    y1 = 1'b0;
                end
                MODE_PAGE, MODE_INQUIRY: begin
                    x  = train_sum(nat);
                    y1 = nat[1];
                end
                MODE_CENTRAL_RSP: begin
                    x  = train_sum(frz) + cnt;
                    y1 = nat[1];
                end
                MODE_PERIPH_RSP: begin
                    x  = frz[16:12] + cnt;
                    y1 = nat[1];
                end
                MODE_INQ_RSP: begin
                    x  = nat[16:12] + cnt;
                    y1 = 1'b1;
                end
                default: begin
                    x  = '0;
                    y1 = 1'b0;
                end
            endcase

            // address keys
            key_a = addr[27:23];
            key_b = addr[22:19];
            key_c = {addr[8], addr[6], addr[4], addr[2], addr[0]};
            key_d = addr[18:10];
            key_e = {addr[13], addr[11], addr[9], addr[7], addr[5], addr[3], addr[1]};

            z   = (x + key_a) ^ {1'b0, key_b};
            cy  = y1 ? ~key_c : key_c;
            ctl = {cy, key_d};

            // butterfly network, highest control first
            for (int i = NUM_FLY - 1; i >= 0; i--) begin
                if (ctl[i]) begin
                    t             = z[SWAP_LO[i]];
                    z[SWAP_LO[i]] = z[SWAP_HI[i]];
                    z[SWAP_HI[i]] = t;
                end
            end

            sum = {3'b000, z} + {1'b0, key_e} + (y1 ? 8'd32 : 8'd0);
            idx = HOP_W'(sum % NUM_CHANNELS);
            res.hop_index  = idx;
            res.rf_channel = (idx < HALF_CHANNELS) ? HOP_W'(2 * idx)
                                                   : HOP_W'(2 * (idx - HALF_CHANNELS) + 1);
            return res;
        endfunction

        function void note_slot(input logic [CLK_W-1:0] nat,
                                input logic [CLK_W-1:0] frz,
                                input logic [CNT_W-1:0] cnt);
            expected_hops.push_back(predict(nat, frz, cnt));
        endfunction

        function int pending();
            return expected_hops.size();
        endfunction

        task report(input string msg);
            if (errors < MAX_PRINTED) begin
                $display("ERROR at %0t: %s", $realtime, msg);
            end
            errors++;
        endtask

        task check_result(input logic [HOP_W-1:0] rf, input logic [HOP_W-1:0] idx);
            hop_result_t want;
            results_checked++;
            if (expected_hops.size() == 0) begin
                report($sformatf("hop result rf=%0d idx=%0d with none pending", rf, idx));
                return;
            end
            want = expected_hops.pop_front();
            if (rf !== want.rf_channel) begin
                report($sformatf("rf_channel got %0d, wanted %0d", rf, want.rf_channel));
            end
            if (idx !== want.hop_index) begin
                report($sformatf("hop_index got %0d, wanted %0d", idx, want.hop_index));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [CLK_W-1:0]      i_native_clock;
    logic [CLK_W-1:0]      i_frozen_clock;
    logic [CNT_W-1:0]      i_response_count;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [HOP_W-1:0]      o_rf_channel;
    logic [HOP_W-1:0]      o_hop_index;

    hop_scoreboard sb;
    bit            running;
    bit            hold_req;
    int            holds_done;
    int            quiet_cycles;
    int            slots_sent;
    int            cfg_writes;
    int            settings_applied;
    logic [NUM_MODES-1:0] modes_seen;

    bt_hop_channel_select uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_native_clock   (i_native_clock),
        .i_frozen_clock   (i_frozen_clock),
        .i_response_count (i_response_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_rf_channel     (o_rf_channel),
        .o_hop_index      (o_hop_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // register write; valid drops the cycle after the transfer
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(index, data);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one slot; valid stays up afterwards so bursts run back to back
    task automatic send_slot(input logic [CLK_W-1:0] nat,
                             input logic [CLK_W-1:0] frz,
                             input logic [CNT_W-1:0] cnt);
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_native_clock   <= nat;
        i_frozen_clock   <= frz;
        i_response_count <= cnt;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_slot(nat, frz, cnt);
        slots_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // stop offering slots until every pending hop is out and the pipe is empty
    task automatic wait_idle();
        idle_sender(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // all four registers, junk in the bits above each width
    task automatic apply_setting(input logic [2:0]         mode,
                                 input logic [ADDR_W-1:0]  address,
                                 input logic [PHASE_W-1:0] offset,
                                 input logic [PHASE_W-1:0] nudge,
                                 input bit                 spare);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_register(CFG_MODE, {junk[CFG_DATA_W-1:3], mode});
        write_register(CFG_ADDRESS, address);
        write_register(CFG_OFFSET, {junk[CFG_DATA_W-1:PHASE_W], offset});
        write_register(CFG_NUDGE, {~junk[CFG_DATA_W-1:PHASE_W], nudge});
        if (spare) begin
            write_register(CFG_IDX_W'($urandom_range(SPARE_INDEX_LO, SPARE_INDEX_HI)),
                           CFG_DATA_W'($urandom));
        end
        modes_seen[mode] = 1'b1;
        settings_applied++;
    endtask

    // mostly consecutive slots of one train, sometimes pure noise
    task automatic send_burst(input int count, input logic [CLK_W-1:0] frz_ref);
        logic [CLK_W-1:0] nat;
        logic [CNT_W-1:0] cnt;
        bit               slot_run;
        slot_run = ($urandom_range(0, 3) != 0);
        nat      = CLK_W'($urandom);
        cnt      = CNT_W'($urandom);
        for (int k = 0; k < count; k++) begin
            if (slot_run) begin
                send_slot(CLK_W'(nat + k), frz_ref, CNT_W'(cnt + k / 2));
            end else begin
                send_slot(CLK_W'($urandom), CLK_W'($urandom), CNT_W'($urandom));
            end
        end
    endtask

    // output side: rotating stall styles, plus the long hold-off on request
    initial begin
        int rx_cycle;
        i_out_ready = 1'b0;
        rx_cycle    = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end else begin
                case ((rx_cycle / 64) % 4)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= ($urandom_range(0, 3) != 0);
                    default: i_out_ready <= ((rx_cycle % 5) < 3);
                endcase
            end
            rx_cycle++;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_rf_channel, o_hop_index);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (running) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [2:0]         mode;
        logic [ADDR_W-1:0]  address;
        logic [PHASE_W-1:0] offset;
        logic [PHASE_W-1:0] nudge;
        logic [CLK_W-1:0]   frz_ref;
        int                 left;
        int                 burst;

        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_native_clock   = '0;
        i_frozen_clock   = '0;
        i_response_count = '0;
        hold_req         = 1'b0;
        modes_seen       = '0;
        sb = new();
        sb.reset_regs();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;

        // directed: reset settings, then every mode with field and register extremes
        modes_seen[MODE_PAGE_SCAN] = 1'b1;
        send_slot(CLK_MAX, CLK_MAX, CNT_MAX);
        for (int m = 0; m < NUM_MODES; m++) begin
            wait_idle();
            apply_setting(3'(m), (m % 2 == 0) ? ADDR_MAX : '0,
                          (m < 4) ? PHASE_MAX : '0, (m < 4) ? PHASE_MAX : '0,
                          m == 1);
            send_slot('0, '0, '0);
            send_slot(CLK_MAX, CLK_MAX, CNT_MAX);
            send_slot(CLK_W'($urandom), CLK_W'($urandom), CNT_W'($urandom));
        end

        // random settings, each with a few dozen slots
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            wait_idle();
            mode = 3'($urandom_range(0, MODE_UNUSED));
            case ($urandom_range(0, 7))
                0:       address = '0;
                1:       address = ADDR_MAX;
                default: address = ADDR_W'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       offset = 5'd24;
                1:       offset = 5'd8;
                2:       offset = '0;
                3:       offset = PHASE_MAX;
                default: offset = PHASE_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       nudge = '0;
                1:       nudge = PHASE_MAX;
                default: nudge = PHASE_W'($urandom);
            endcase
            apply_setting(mode, address, offset, nudge, $urandom_range(0, 3) == 0);

            frz_ref = CLK_W'($urandom);
            left    = SLOTS_PER_SETTING;
            // output held off while slots keep coming, so the input backs up
            if (s == HOLD_SETTING) begin
                hold_req = 1'b1;
                send_burst(HOLD_SLOTS, frz_ref);
                left -= HOLD_SLOTS;
            end
            while (left > 0) begin
                burst = $urandom_range(1, 16);
                if (burst > left) begin
                    burst = left;
                end
                send_burst(burst, frz_ref);
                left -= burst;
                if ($urandom_range(0, 9) < 7) begin
                    idle_sender($urandom_range(1, 6));
                end
            end
        end

        wait_idle();
        $display("Covered %0d slot transfers, %0d hop results, %0d register writes",
                 slots_sent, sb.results_checked, cfg_writes);
        $display("over %0d settings, %0d of %0d mode codes, %0d output hold-off(s).",
                 settings_applied, $countones(modes_seen), NUM_MODES, holds_done);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d hops still pending", sb.errors, sb.pending());
            $display("FAIL");
        end
        $finish;
    end

endmodule
